[rtl/ulbt_pkg.sv]
// Shared types and constants for the UART receive line buffer tokenizer.
// Holds the item/result beat structs, op codes and controller/datapath link types.
// No dependencies.
package ulbt_pkg;

    localparam logic [2:0] OP_RX    = 3'd0;
    localparam logic [2:0] OP_TAKE  = 3'd1;
    localparam logic [2:0] OP_COUNT = 3'd2;
    localparam logic [2:0] OP_WORD  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic [2:0] op;
        logic       port;
        logic [7:0] rx_byte;
        logic [1:0] slot_sel;
        logic [5:0] byte_offset;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [1:0] line_slot;
        logic [5:0] span_length;
        logic [5:0] word_start;
        logic [5:0] word_total;
        logic [7:0] read_data;
    } out_item_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_EMPTY,
        EMIT_TAKE,
        EMIT_BYTE,
        EMIT_COUNT,
        EMIT_WORD
    } emit_t;

    typedef struct packed {
        logic  load;
        logic  rx_write;
        logic  len_rd_take;
        logic  len_rd_taken;
        logic  byte_rd;
        logic  scan_init;
        logic  scan_step;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       line_ready;
        logic       byte_in_range;
        logic       scan_done;
    } stat_t;

endpackage

[rtl/ulbt_ctrl.sv]
// Sequencing state machine of the line buffer tokenizer.
// Depends on ulbt_pkg; drives commands into ulbt_datapath.
module ulbt_ctrl
    import ulbt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LEN,
        S_SCAN,
        S_TAKE,
        S_BYTE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    OP_RX:
                    begin
                        cmd.rx_write = 1'b1;
                    end
                    OP_TAKE:
                    begin
                        if (stat.line_ready)
                        begin
                            cmd.len_rd_take = 1'b1;
                            state_next      = S_TAKE;
                        end
                        else
                        begin
                            cmd.emit = EMIT_EMPTY;
                        end
                    end
                    OP_COUNT, OP_WORD:
                    begin
                        cmd.len_rd_taken = 1'b1;
                        state_next       = S_LEN;
                    end
                    OP_READ:
                    begin
                        if (stat.byte_in_range)
                        begin
                            cmd.byte_rd = 1'b1;
                            state_next  = S_BYTE;
                        end
                        else
                        begin
                            cmd.emit = EMIT_EMPTY;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LEN:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.emit   = (stat.op == OP_WORD) ? EMIT_WORD : EMIT_COUNT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_TAKE:
            begin
                cmd.emit   = EMIT_TAKE;
                state_next = S_IDLE;
            end
            S_BYTE:
            begin
                cmd.emit   = EMIT_BYTE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/ulbt_datapath.sv]
// Datapath of the line buffer tokenizer: line store, length memory, per-port
// ring pointers, byte scanner and result register. Depends on ulbt_pkg.
module ulbt_datapath
    import ulbt_pkg::*;
#(
    parameter int NUM_PORTS  = 2,
    parameter int LINE_SLOTS = 4,
    parameter int LINE_BYTES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  cmd_t      cmd,
    output stat_t     stat,
    output logic      done,
    output out_item_t result
);

    localparam int PW     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int SW     = $clog2(LINE_SLOTS);
    localparam int BW     = $clog2(LINE_BYTES);
    localparam int CW     = BW + 1;
    localparam int LAW    = PW + SW;
    localparam int AW     = LAW + BW;
    localparam int SDEPTH = 1 << AW;
    localparam int LDEPTH = 1 << LAW;

    in_item_t        item_reg;
    logic [PW-1:0]   port_reg;

    logic [SW-1:0]   wr_slot_reg [NUM_PORTS];
    logic [SW-1:0]   rd_slot_reg [NUM_PORTS];
    logic [SW-1:0]   tk_slot_reg [NUM_PORTS];
    logic [BW-1:0]   fill_reg    [NUM_PORTS];
    logic [CW-1:0]   cursor_reg  [NUM_PORTS];

    logic [7:0]      store_mem [SDEPTH];
    logic [BW-1:0]   len_mem   [LDEPTH];
    logic [7:0]      store_rd_reg;
    logic [BW-1:0]   len_rd_reg;

    logic [BW-1:0]   scan_len_reg;
    logic [BW-1:0]   idx_reg;
    logic [BW-1:0]   start_reg;
    logic [BW-1:0]   count_reg;
    logic            in_word_reg;

    out_item_t       res_reg, res_next;
    logic            done_reg;

    logic [SW-1:0]   ws, rs, ts, ws_inc, ssel_idx;
    logic [BW-1:0]   fill, boff_idx, scan_start;
    logic [CW-1:0]   cursor;
    logic            is_ctrl_byte, line_full, at_end, word_byte, op_is_word, scan_done;
    logic [AW-1:0]   store_wr_addr, store_rd_addr;
    logic [LAW-1:0]  len_wr_addr, len_rd_addr;

    assign ws     = wr_slot_reg[port_reg];
    assign rs     = rd_slot_reg[port_reg];
    assign ts     = tk_slot_reg[port_reg];
    assign fill   = fill_reg[port_reg];
    assign cursor = cursor_reg[port_reg];

    assign ws_inc       = (ws == SW'(LINE_SLOTS - 1)) ? '0 : ws + 1'b1;
    assign is_ctrl_byte = item_reg.rx_byte < SPACE_CHAR;
    assign line_full    = fill >= BW'(LINE_BYTES - 1);
    assign ssel_idx     = SW'(item_reg.slot_sel);
    assign boff_idx     = BW'(item_reg.byte_offset);
    assign op_is_word   = item_reg.op == OP_WORD;

    // Next word resumes at the cursor, clamped to the line length.
    always_comb
    begin
        scan_start = '0;
        if (op_is_word)
        begin
            scan_start = (cursor > {1'b0, len_rd_reg}) ? len_rd_reg : BW'(cursor);
        end
    end

    assign at_end    = idx_reg >= scan_len_reg;
    assign word_byte = store_rd_reg > SPACE_CHAR;
    assign scan_done = at_end | (!word_byte & (op_is_word | !in_word_reg));

    assign store_wr_addr = {port_reg, ws, fill};
    assign len_wr_addr   = {port_reg, ws};
    assign len_rd_addr   = cmd.len_rd_take ? {port_reg, rs} : {port_reg, ts};

    always_comb
    begin
        if (cmd.byte_rd)
        begin
            store_rd_addr = {port_reg, ssel_idx, boff_idx};
        end
        else if (cmd.scan_init)
        begin
            store_rd_addr = {port_reg, ts, scan_start};
        end
        else
        begin
            store_rd_addr = {port_reg, ts, idx_reg + 1'b1};
        end
    end

    // Hold the accepted item for the whole operation.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
            port_reg <= (int'(item.port) < NUM_PORTS) ? PW'(item.port) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_write && !is_ctrl_byte && !line_full)
        begin
            store_mem[store_wr_addr] <= item_reg.rx_byte;
        end
        if (cmd.byte_rd || cmd.scan_init || cmd.scan_step)
        begin
            store_rd_reg <= store_mem[store_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_write && is_ctrl_byte)
        begin
            len_mem[len_wr_addr] <= fill;
        end
        if (cmd.len_rd_take || cmd.len_rd_taken)
        begin
            len_rd_reg <= len_mem[len_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                wr_slot_reg[i] <= '0;
                rd_slot_reg[i] <= '0;
                tk_slot_reg[i] <= '0;
                fill_reg[i]    <= '0;
                cursor_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.rx_write)
            begin
                if (is_ctrl_byte)
                begin
                    fill_reg[port_reg]    <= '0;
                    wr_slot_reg[port_reg] <= ws_inc;
                end
                else if (!line_full)
                begin
                    fill_reg[port_reg] <= fill + 1'b1;
                end
            end
            case (cmd.emit)
                EMIT_TAKE:
                begin
                    tk_slot_reg[port_reg] <= rs;
                    rd_slot_reg[port_reg] <= ws;
                    cursor_reg[port_reg]  <= '0;
                end
                EMIT_COUNT:
                begin
                    cursor_reg[port_reg] <= '0;
                end
                EMIT_WORD:
                begin
                    cursor_reg[port_reg] <= CW'(idx_reg) + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Byte scanner: one stored byte evaluated per cycle, next byte prefetched.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_len_reg <= len_rd_reg;
            idx_reg      <= scan_start;
            start_reg    <= scan_start;
            count_reg    <= '0;
            in_word_reg  <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!in_word_reg)
            begin
                count_reg   <= count_reg + 1'b1;
                in_word_reg <= 1'b1;
            end
            else if (!word_byte)
            begin
                in_word_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        res_next = '0;
        case (cmd.emit)
            EMIT_TAKE:
            begin
                res_next.found       = 1'b1;
                res_next.line_slot   = 2'(rs);
                res_next.span_length = 6'(len_rd_reg);
            end
            EMIT_BYTE:
            begin
                res_next.read_data = store_rd_reg;
            end
            EMIT_COUNT:
            begin
                res_next.word_total = 6'(count_reg);
            end
            EMIT_WORD:
            begin
                res_next.span_length = 6'(idx_reg - start_reg);
                res_next.word_start  = 6'(start_reg);
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit != EMIT_NONE;
        end
    end

    assign stat.op            = item_reg.op;
    assign stat.line_ready    = rs != ws;
    assign stat.byte_in_range = (int'(item_reg.slot_sel) < LINE_SLOTS)
                              && (int'(item_reg.byte_offset) < LINE_BYTES);
    assign stat.scan_done     = scan_done;

    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/uart_line_buffer_tokenizer_core.sv]
// Receive byte keeps busy for its decode state only and gives no result; take line
// and read byte emit in decode when no line is ready or the byte is out of range,
// else from the take or byte state; count words and next word pass the length and
// scan states, the scan reading the line store one byte per cycle. done is registered
// after the emit; new beats are taken only in idle. Reset clears pointers, fill counts
// and control; line store and length memory are not cleared, junk until written.
module uart_line_buffer_tokenizer_core
    import ulbt_pkg::*;
#(
    parameter int NUM_PORTS  = 2,
    parameter int LINE_SLOTS = 4,
    parameter int LINE_BYTES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      done,
    output out_item_t result
);

    // Command and status link between the sequencer and the datapath.
    cmd_t  cmd;
    stat_t stat;

    // Sequencer: accept a beat, dispatch on the op, walk the scan, emit.
    ulbt_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Datapath: hold the line ring per port, scan bytes, register the result beat.
    ulbt_datapath
    #(
        .NUM_PORTS  (NUM_PORTS),
        .LINE_SLOTS (LINE_SLOTS),
        .LINE_BYTES (LINE_BYTES)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    // An accepted beat always occupies the block for at least the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Idle always lies between two emits, so result strobes never come back to back.
    a_no_double_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on two consecutive cycles");

    // A result only follows a cycle in which an item was in progress.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in progress");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for uart_line_buffer_tokenizer_core: line receive, take line,
// word count, word walk and byte read-back, predicted in place and checked per beat.
// Depends on ulbt_pkg (beat structs, op codes, SPACE_CHAR) and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ulbt_pkg::*;

    localparam int NUM_PORTS    = 2;
    localparam int LINE_SLOTS   = 4;
    localparam int LINE_BYTES   = 64;
    localparam int RANDOM_BEATS = 1400;
    // Run limit; the slowest beat is the longest sender gap + a full line scan + handshake overhead.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = LINE_BYTES + 8;
    // Top of the op field; codes above OP_READ are not decoded by the core.
    localparam logic [2:0] OP_LAST = 3'd7;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  item  = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    uart_line_buffer_tokenizer_core #(
        .NUM_PORTS  (NUM_PORTS),
        .LINE_SLOTS (LINE_SLOTS),
        .LINE_BYTES (LINE_BYTES)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the line buffer, one copy per receive port.
    // ------------------------------------------------------------------
    logic [7:0] line_bytes   [NUM_PORTS][LINE_SLOTS][LINE_BYTES];
    logic [5:0] line_len     [NUM_PORTS][LINE_SLOTS];
    logic [1:0] wr_slot      [NUM_PORTS];
    logic [1:0] rd_slot      [NUM_PORTS];
    logic [1:0] cur_slot     [NUM_PORTS];
    logic [5:0] fill_count   [NUM_PORTS];
    logic [6:0] word_pos     [NUM_PORTS];
    // Bytes are always written from offset 0 upward, so a high-water mark per
    // slot tells exactly which entries hold defined data.
    int         written_len  [NUM_PORTS][LINE_SLOTS];
    bit         line_held    [NUM_PORTS];

    out_item_t  expected_results[$];

    int errors          = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int lines_taken     = 0;
    int sender_gap_max  = 10;
    int cycle_count;

    initial
    begin
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            wr_slot[p]    = '0;
            rd_slot[p]    = '0;
            cur_slot[p]   = '0;
            fill_count[p] = '0;
            word_pos[p]   = '0;
            line_held[p]  = 1'b0;
            for (int s = 0; s < LINE_SLOTS; s++)
            begin
                line_len[p][s]    = '0;
                written_len[p][s] = 0;
            end
        end
    end

    // Apply one accepted beat to the shadow and queue the result it must produce.
    task automatic predict_line_buffer(input in_item_t it);
        out_item_t r;
        bit        has_result;
        int        p;
        int        s;
        int        len;
        int        i;
        int        n;
        int        first;
        int        last;
        r          = '0;
        has_result = 1'b1;
        p          = int'(it.port);
        s          = int'(cur_slot[p]);
        len        = int'(line_len[p][s]);
        case (it.op)
            OP_RX:
            begin
                has_result = 1'b0;
                s = int'(wr_slot[p]);
                if (it.rx_byte < SPACE_CHAR)
                begin
                    // Close the line and advance the ring.
                    line_len[p][s] = fill_count[p];
                    fill_count[p]  = '0;
                    wr_slot[p]     = 2'((s + 1) % LINE_SLOTS);
                end
                else if (fill_count[p] < LINE_BYTES - 1)
                begin
                    line_bytes[p][s][fill_count[p]] = it.rx_byte;
                    fill_count[p] = fill_count[p] + 1'b1;
                    if (int'(fill_count[p]) > written_len[p][s])
                        written_len[p][s] = int'(fill_count[p]);
                end
            end
            OP_TAKE:
            begin
                if (rd_slot[p] != wr_slot[p])
                begin
                    r.found       = 1'b1;
                    r.line_slot   = rd_slot[p];
                    r.span_length = line_len[p][rd_slot[p]];
                    cur_slot[p]   = rd_slot[p];
                    rd_slot[p]    = wr_slot[p];
                    word_pos[p]   = '0;
                    line_held[p]  = 1'b1;
                    lines_taken++;
                end
            end
            OP_COUNT:
            begin
                i = 0;
                n = 0;
                while (i < len && line_bytes[p][s][i] > SPACE_CHAR)
                begin
                    n++;
                    while (i < len && line_bytes[p][s][i] > SPACE_CHAR)
                        i++;
                    i++;
                end
                word_pos[p]  = '0;
                r.word_total = 6'(n);
            end
            OP_WORD:
            begin
                first = int'(word_pos[p]);
                if (first > len)
                    first = len;
                last = first;
                while (last < len && line_bytes[p][s][last] > SPACE_CHAR)
                    last++;
                word_pos[p]   = 7'(last + 1);
                r.span_length = 6'(last - first);
                r.word_start  = 6'(first);
            end
            OP_READ:
                r.read_data = line_bytes[p][it.slot_sel][it.byte_offset];
            default:
                has_result = 1'b0;
        endcase
        if (has_result)
            expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------
    // Drive one beat and hold it until the core takes it. Start stays high
    // after acceptance so back-to-back beats never drop it within a step.
    task automatic send_beat(input in_item_t it);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_line_buffer(it);
        if (it.op <= OP_READ)
            beats_sent++;
    endtask

    function automatic in_item_t random_item(input logic [2:0] op, input int p);
        logic [31:0] raw;
        in_item_t    it;
        raw     = $urandom;
        it      = raw[$bits(in_item_t)-1:0];
        it.op   = op;
        it.port = p[0];
        return it;
    endfunction

    function automatic logic [7:0] word_byte();
        return 8'($urandom_range(SPACE_CHAR + 1, 8'hFF));
    endfunction

    function automatic logic [7:0] control_byte();
        return 8'($urandom_range(0, SPACE_CHAR - 1));
    endfunction

    task automatic send_rx(input int p, input logic [7:0] b);
        in_item_t it;
        it         = random_item(OP_RX, p);
        it.rx_byte = b;
        send_beat(it);
    endtask

    // Send any op with random don't-care fields. Steer away from storage that was
    // never written: a count or word op before any take, or a read on a port with
    // no written bytes, turns into a take line; other reads pick a written entry.
    task automatic send_op(input logic [2:0] op, input int p);
        in_item_t it;
        int       s;
        bit       any_bytes;
        it        = random_item(op, p);
        any_bytes = 1'b0;
        for (int k = 0; k < LINE_SLOTS; k++)
            if (written_len[p][k] > 0)
                any_bytes = 1'b1;
        if ((op == OP_COUNT || op == OP_WORD) && !line_held[p])
            it.op = OP_TAKE;
        else if (op == OP_READ && !any_bytes)
            it.op = OP_TAKE;
        else if (op == OP_READ)
        begin
            do
                s = $urandom_range(0, LINE_SLOTS - 1);
            while (written_len[p][s] == 0);
            it.slot_sel    = 2'(s);
            it.byte_offset = 6'($urandom_range(0, written_len[p][s] - 1));
        end
        send_beat(it);
    endtask

    // Well-formed line: words split by single spaces, now and then a doubled
    // or leading space, closed by a random control byte.
    task automatic send_word_line(input int p, input int nwords);
        if ($urandom_range(0, 19) == 0)
            send_rx(p, SPACE_CHAR);
        for (int w = 0; w < nwords; w++)
        begin
            if (w > 0)
            begin
                send_rx(p, SPACE_CHAR);
                if ($urandom_range(0, 9) == 0)
                    send_rx(p, SPACE_CHAR);
            end
            repeat ($urandom_range(1, 8)) send_rx(p, word_byte());
        end
        send_rx(p, control_byte());
    endtask

    // Line that runs into the full-line limit (or just short of it).
    task automatic send_long_line(input int p);
        repeat ($urandom_range(LINE_BYTES - 9, LINE_BYTES + 16))
            send_rx(p, ($urandom_range(0, 4) == 0) ? SPACE_CHAR : word_byte());
        send_rx(p, control_byte());
    endtask

    // Take a line and pick it apart: optional count, a walk of words that may
    // run past the end, and a few byte reads.
    task automatic query_line(input int p, input int word_steps);
        send_op(OP_TAKE, p);
        if ($urandom_range(0, 1) == 1)
            send_op(OP_COUNT, p);
        repeat ($urandom_range(1, word_steps + 2)) send_op(OP_WORD, p);
        repeat ($urandom_range(0, 2)) send_op(OP_READ, p);
    endtask

    // Hold start low and wait until every queued result has come back.
    task automatic wait_results_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // Fresh ports: nothing to take; undecoded op codes must stay silent.
    task automatic test_empty_ports();
        send_op(OP_TAKE, 0);
        send_op(OP_TAKE, 1);
        for (int op = OP_READ + 1; op <= OP_LAST; op++)
            send_beat(random_item(3'(op), $urandom_range(0, 1)));
    endtask

    // Known line on port 0: a double space stops the count early, and the
    // word walk steps over it and then past the end of the line.
    task automatic test_word_split();
        in_item_t it;
        send_rx(0, 8'hFF);
        send_rx(0, SPACE_CHAR);
        send_rx(0, 8'h21);
        send_rx(0, SPACE_CHAR);
        send_rx(0, SPACE_CHAR);
        send_rx(0, 8'h7E);
        send_rx(0, 8'(SPACE_CHAR - 1));
        send_op(OP_TAKE, 0);
        send_op(OP_COUNT, 0);
        repeat (5) send_op(OP_WORD, 0);
        it             = random_item(OP_READ, 0);
        it.slot_sel    = '0;
        it.byte_offset = '0;
        send_beat(it);
        it.byte_offset = 6'd5;
        send_beat(it);
    endtask

    // Zero-length line on port 1.
    task automatic test_empty_line();
        send_rx(1, 8'h00);
        send_op(OP_TAKE, 1);
        send_op(OP_COUNT, 1);
        send_op(OP_WORD, 1);
    endtask

    // Overfill a line: bytes past LINE_BYTES-1 are dropped; read the last kept one.
    task automatic test_full_line();
        in_item_t it;
        repeat (LINE_BYTES + 6)
            send_rx(1, ($urandom_range(0, 5) == 0) ? SPACE_CHAR : word_byte());
        send_rx(1, control_byte());
        query_line(1, 12);
        it             = random_item(OP_READ, 1);
        it.slot_sel    = cur_slot[1];
        it.byte_offset = 6'(LINE_BYTES - 2);
        send_beat(it);
    endtask

    // Fill the whole ring without taking: write slot meets read slot again and
    // take line finds nothing; one more line makes it available.
    task automatic test_ring_wrap();
        repeat (LINE_SLOTS) send_word_line(0, $urandom_range(0, 4));
        send_op(OP_TAKE, 0);
        send_word_line(0, $urandom_range(1, 5));
        query_line(0, 5);
    endtask

    // Mostly well-formed line sessions with random content, mixed with
    // overlong lines, queued-up lines and raw noise beats.
    task automatic test_random_sessions(input int beat_goal);
        int p;
        int pick;
        int nwords;
        while (beats_sent < beat_goal)
        begin
            p              = $urandom_range(0, NUM_PORTS - 1);
            pick           = $urandom_range(0, 99);
            // Alternate stretches with no idling and stretches with random gaps.
            sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            if (pick < 55)
            begin
                nwords = $urandom_range(0, 6);
                send_word_line(p, nwords);
                if ($urandom_range(0, 9) < 7)
                    query_line(p, nwords);
            end
            else if (pick < 65)
            begin
                send_long_line(p);
                query_line(p, 20);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(5, 15))
                    send_op(3'($urandom_range(0, OP_LAST)), $urandom_range(0, NUM_PORTS - 1));
            end
            else
            begin
                repeat ($urandom_range(2, LINE_SLOTS + 1))
                    send_word_line(p, $urandom_range(0, 5));
                query_line(p, 5);
            end
        end
    endtask

    // Pause the sender until the core has answered everything, then resume.
    task automatic test_drain_pause();
        send_word_line(0, 3);
        query_line(0, 3);
        wait_results_drained();
        repeat ($urandom_range(1, 20)) @(posedge clk);
        send_op(OP_COUNT, 0);
    endtask

    // ------------------------------------------------------------------
    // Result checking: every done beat is matched against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, actual %p", $time, result);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("found",       8'(want.found),       8'(result.found));
                check_field("line_slot",   8'(want.line_slot),   8'(result.line_slot));
                check_field("span_length", 8'(want.span_length), 8'(result.span_length));
                check_field("word_start",  8'(want.word_start),  8'(result.word_start));
                check_field("word_total",  8'(want.word_total),  8'(result.word_total));
                check_field("read_data",   want.read_data,       result.read_data);
                results_checked++;
            end
        end
    end

    // Watchdog: end the run if the core stops answering.
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
        $display("[uart_line_buffer_tokenizer_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ports();
        test_word_split();
        test_empty_line();
        test_full_line();
        test_ring_wrap();
        test_random_sessions(beats_sent + RANDOM_BEATS / 2);
        test_drain_pause();
        test_random_sessions(beats_sent + RANDOM_BEATS / 2);

        // Let the last word scan finish and catch any stray result beat.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end

        $display("Run: %0d beats on both ports, %0d lines taken, %0d results compared",
                 beats_sent, lines_taken, results_checked);
        $display("     in %0d cycles, %0d mismatches", cycle_count, errors);
        if (errors == 0)
            $display("[uart_line_buffer_tokenizer_core] OK");
        else
            $display("[uart_line_buffer_tokenizer_core] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/ulbt_pkg.sv
rtl/ulbt_ctrl.sv
rtl/ulbt_datapath.sv
rtl/uart_line_buffer_tokenizer_core.sv
tb/tb_top.sv
